// File: sv/sem_pkg.sv
// shared constants and types of the sobel edge magnitude block
package sem_pkg;

  localparam int PIX_W      = 8;
  localparam int MAG_W      = 8;
  localparam int ROW_W      = 12;
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int GRAD_W     = 11;
  localparam int RAD_W      = 21;
  localparam int ROOT_W     = 16;

  localparam int WIDTH_RST  = 1024;
  localparam int HEIGHT_RST = 768;
  localparam int H_LIMIT    = 4096;
  localparam int SAT_LIMIT  = 65025;

  localparam logic [MAG_W-1:0]     MAG_MAX   = 8'hFF;
  localparam logic [ROOT_W-1:0]    SQRT_BIT0 = 16'h4000;
  localparam logic [ROOT_W-1:0]    SQRT_BITN = 16'h0001;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

  // which neighborhood a result uses relative to the newest window
  localparam logic [1:0] KIND_CENTER = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_BOTTOM = 2'd2;
  localparam logic [1:0] KIND_CORNER = 2'd3;

  typedef logic [8:0][PIX_W-1:0] win_t;

endpackage

// File: sv/sem_ram.sv
// generic single-port ram with registered read
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sem_isqrt.sv
// bit-serial integer square root with saturation at 255
module sem_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sem_pkg::RAD_W-1:0]  radicand_i,
  output logic                       done_o,
  output logic [sem_pkg::MAG_W-1:0]  root_o
);
  import sem_pkg::*;

  logic [RAD_W-1:0]  n_q;
  logic [ROOT_W-1:0] root_q;
  logic [ROOT_W-1:0] bit_q;
  logic              busy_q;
  logic              done_q;
  logic [ROOT_W:0]   trial;
  logic              fits;
  logic              sat;

  assign trial = {1'b0, root_q} + {1'b0, bit_q};
  assign fits  = {{(RAD_W-ROOT_W-1){1'b0}}, trial} <= n_q;
  assign sat   = (bit_q == SQRT_BIT0) && (n_q >= RAD_W'(SAT_LIMIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (sat || bit_q == SQRT_BITN)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      root_q <= '0;
      bit_q  <= SQRT_BIT0;
    end else if (busy_q) begin
      if (sat) begin
        root_q <= {{(ROOT_W-MAG_W){1'b0}}, MAG_MAX};
      end else begin
        if (fits) begin
          n_q    <= n_q - {{(RAD_W-ROOT_W-1){1'b0}}, trial};
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q[MAG_W-1:0];

endmodule

// File: sv/sobel_edge_magnitude_3x3.sv
// top level: streaming 3x3 sobel gradient magnitude over one 8-bit plane
//
// Pixels enter on the in channel (in_valid_i/in_ready_o, pixel_i) in raster
// order. Each pixel causes zero to four results on the out channel
// (out_valid_o/out_ready_i), each carrying the magnitude, its column and row,
// a last-of-run mark on the final result of that pixel and frame done on the
// final result of the frame. Frame size is set through the cfg channel
// (index 0 image width, index 1 image height), written between frames.
// One pixel is worked at a time. A pixel that causes no result goes through
// the line store read, then the write back. Each result then goes through
// the gradient, the square sum, the bit-serial square root at one result bit
// per cycle (cut short when it saturates), and the output load.
// Both line stores share one ram entry per column, addressed for reading in
// the cycle the pixel is accepted and written back in the next cycle, so no
// two accesses overlap. A finished result sits in the output register while
// the next pixel is taken; if the receiver stalls, the next result waits in
// the push state. Reset clears the window, the counters and both channels;
// line store contents are not cleared and are always written before use.
module sobel_edge_magnitude_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sem_pkg::PIX_W-1:0]        pixel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sem_pkg::MAG_W-1:0]        magnitude_o,
  output logic [$clog2(MAX_WIDTH)-1:0]     out_col_o,
  output logic [sem_pkg::ROW_W-1:0]        out_row_o,
  output logic                             last_of_run_o,
  output logic                             frame_done_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [sem_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import sem_pkg::*;

  localparam int ColW      = $clog2(MAX_WIDTH);
  localparam int RstWidth  = (MAX_WIDTH < WIDTH_RST) ? MAX_WIDTH : WIDTH_RST;
  localparam int LineW     = 2 * PIX_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_GRAD = 6'b000100,
    ST_SQR  = 6'b001000,
    ST_ROOT = 6'b010000,
    ST_PUSH = 6'b100000
  } state_e;

  state_e                   state_q, state_d;
  logic [ColW-1:0]          last_col_q;
  logic [ROW_W-1:0]         last_row_q;
  logic [ColW-1:0]          width_last;
  logic [ROW_W-1:0]         height_last;
  logic [31:0]              w_ext;
  logic [HGT_W-1:0]         h_val;

  logic [ColW-1:0]          col_q;
  logic [ROW_W-1:0]         row_q;
  logic [ColW-1:0]          cur_c_q;
  logic [ROW_W-1:0]         cur_r_q;
  logic [PIX_W-1:0]         px_q;
  win_t                     win_q;
  logic [3:0]               pend_q;
  logic [1:0]               kind_q;
  logic [1:0]               kind_sel;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic signed [GRAD_W-1:0] gx_c, gy_c;

  logic                     ram_we;
  logic [ColW-1:0]          ram_addr;
  logic [LineW-1:0]         ram_wdata;
  logic [LineW-1:0]         ram_rdata;
  logic [PIX_W-1:0]         top_px, mid_px;
  logic                     is_last_col, is_last_row;
  logic [3:0]               pend_new;

  logic signed [2*GRAD_W-1:0] sq_x, sq_y;
  logic [RAD_W-1:0]         radicand;
  logic                     root_done;
  logic [MAG_W-1:0]         root_val;

  logic                     out_valid_q;
  logic [MAG_W-1:0]         mag_q;
  logic [ColW-1:0]          ocol_q;
  logic [ROW_W-1:0]         orow_q;
  logic                     olast_q;
  logic                     oframe_q;
  logic                     out_free;
  logic [3:0]               pend_rest;
  logic                     sel_left, sel_up;

  // configuration, clamped to the supported range when written
  assign cfg_ready_o = 1'b1;

  always_comb begin
    w_ext = 32'(cfg_data_i[WID_W-1:0]);
    h_val = cfg_data_i[HGT_W-1:0];
    if (w_ext == 32'd0) begin
      width_last = '0;
    end else if (w_ext > 32'(MAX_WIDTH)) begin
      width_last = ColW'(MAX_WIDTH - 1);
    end else begin
      width_last = ColW'(w_ext - 32'd1);
    end
    if (h_val == '0) begin
      height_last = '0;
    end else if (h_val > HGT_W'(H_LIMIT)) begin
      height_last = ROW_W'(H_LIMIT - 1);
    end else begin
      height_last = ROW_W'(h_val - HGT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_col_q <= ColW'(RstWidth - 1);
      last_row_q <= ROW_W'(HEIGHT_RST - 1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH:  last_col_q <= width_last;
        CFG_IMAGE_HEIGHT: last_row_q <= height_last;
        default: ;
      endcase
    end
  end

  // line stores: {older, newer} per column
  assign ram_we    = (state_q == ST_LOAD);
  assign ram_addr  = (state_q == ST_LOAD) ? cur_c_q : col_q;
  assign ram_wdata = {ram_rdata[PIX_W-1:0], px_q};

  sem_ram #(
    .WIDTH (LineW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign mid_px      = (cur_r_q >= ROW_W'(1)) ? ram_rdata[PIX_W-1:0] : '0;
  assign top_px      = (cur_r_q >= ROW_W'(2)) ? ram_rdata[LineW-1:PIX_W] : '0;
  assign is_last_col = cur_c_q >= last_col_q;
  assign is_last_row = cur_r_q >= last_row_q;

  always_comb begin
    pend_new              = '0;
    pend_new[KIND_CENTER] = (cur_r_q != '0) && (cur_c_q != '0);
    pend_new[KIND_RIGHT]  = (cur_r_q != '0) && is_last_col;
    pend_new[KIND_BOTTOM] = is_last_row && (cur_c_q != '0);
    pend_new[KIND_CORNER] = is_last_row && is_last_col;
  end

  // earliest pending result in raster order
  always_comb begin
    if (pend_q[KIND_CENTER]) begin
      kind_sel = KIND_CENTER;
    end else if (pend_q[KIND_RIGHT]) begin
      kind_sel = KIND_RIGHT;
    end else if (pend_q[KIND_BOTTOM]) begin
      kind_sel = KIND_BOTTOM;
    end else begin
      kind_sel = KIND_CORNER;
    end
  end

  // gradients over the window, shifted with zero fill for the edge results
  always_comb begin
    logic [2:0][2:0][PIX_W-1:0] p;
    logic [PIX_W+1:0]           pos_x, neg_x, pos_y, neg_y;
    logic                       su, sl;
    sl = (kind_sel == KIND_RIGHT) || (kind_sel == KIND_CORNER);
    su = (kind_sel == KIND_BOTTOM) || (kind_sel == KIND_CORNER);
    for (int rr = 0; rr < 3; rr++) begin
      for (int cc = 0; cc < 3; cc++) begin
        p[rr][cc] = win_q[rr * 3 + cc];
      end
    end
    if (sl) begin
      for (int rr = 0; rr < 3; rr++) begin
        p[rr][0] = p[rr][1];
        p[rr][1] = p[rr][2];
        p[rr][2] = '0;
      end
    end
    if (su) begin
      for (int cc = 0; cc < 3; cc++) begin
        p[0][cc] = p[1][cc];
        p[1][cc] = p[2][cc];
        p[2][cc] = '0;
      end
    end
    pos_x = {2'b00, p[0][2]} + {1'b0, p[1][2], 1'b0} + {2'b00, p[2][2]};
    neg_x = {2'b00, p[0][0]} + {1'b0, p[1][0], 1'b0} + {2'b00, p[2][0]};
    pos_y = {2'b00, p[2][0]} + {1'b0, p[2][1], 1'b0} + {2'b00, p[2][2]};
    neg_y = {2'b00, p[0][0]} + {1'b0, p[0][1], 1'b0} + {2'b00, p[0][2]};
    gx_c  = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
    gy_c  = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
  end

  assign sq_x     = gx_q * gx_q;
  assign sq_y     = gy_q * gy_q;
  assign radicand = {1'b0, sq_x[RAD_W-2:0]} + {1'b0, sq_y[RAD_W-2:0]};

  sem_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_SQR),
    .radicand_i (radicand),
    .done_o     (root_done),
    .root_o     (root_val)
  );

  assign out_free  = !out_valid_q || out_ready_i;
  assign pend_rest = pend_q & ~(4'b0001 << kind_q);
  assign sel_left  = (kind_q == KIND_RIGHT) || (kind_q == KIND_CORNER);
  assign sel_up    = (kind_q == KIND_BOTTOM) || (kind_q == KIND_CORNER);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_LOAD;
      ST_LOAD: state_d = (pend_new == '0) ? ST_IDLE : ST_GRAD;
      ST_GRAD: state_d = ST_SQR;
      ST_SQR:  state_d = ST_ROOT;
      ST_ROOT: if (root_done) state_d = ST_PUSH;
      ST_PUSH: begin
        if (out_free) begin
          state_d = (pend_rest == '0) ? ST_IDLE : ST_GRAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PUSH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            win_q[i * 3]     <= (cur_c_q == '0) ? '0 : win_q[i * 3 + 1];
            win_q[i * 3 + 1] <= (cur_c_q == '0) ? '0 : win_q[i * 3 + 2];
          end
          win_q[2] <= top_px;
          win_q[5] <= mid_px;
          win_q[8] <= px_q;
          pend_q   <= pend_new;
          if (is_last_col) begin
            col_q <= '0;
            row_q <= is_last_row ? '0 : cur_r_q + ROW_W'(1);
          end else begin
            col_q <= cur_c_q + ColW'(1);
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            pend_q <= pend_rest;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      px_q    <= pixel_i;
      cur_c_q <= col_q;
      cur_r_q <= row_q;
    end
    if (state_q == ST_GRAD) begin
      gx_q   <= gx_c;
      gy_q   <= gy_c;
      kind_q <= kind_sel;
    end
    if (state_q == ST_PUSH && out_free) begin
      mag_q    <= root_val;
      ocol_q   <= sel_left ? cur_c_q : cur_c_q - ColW'(1);
      orow_q   <= sel_up ? cur_r_q : cur_r_q - ROW_W'(1);
      olast_q  <= (pend_rest == '0);
      oframe_q <= (kind_q == KIND_CORNER);
    end
  end

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign magnitude_o   = mag_q;
  assign out_col_o     = ocol_q;
  assign out_row_o     = orow_q;
  assign last_of_run_o = olast_q;
  assign frame_done_o  = oframe_q;

endmodule

// File: sv/sem_checker.sv
// port-level checks of the sobel edge magnitude block, bound to the top level
module sem_checker #(
  parameter int MAX_WIDTH = 1024
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [sem_pkg::MAG_W-1:0]      magnitude_o,
  input logic [$clog2(MAX_WIDTH)-1:0]   out_col_o,
  input logic [sem_pkg::ROW_W-1:0]      out_row_o,
  input logic                           last_of_run_o,
  input logic                           frame_done_o
);
  import sem_pkg::*;

  // a pending result stays offered
  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o;
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped while stalled");

  // a stalled result keeps its payload
  property p_out_stable;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> $stable(magnitude_o) && $stable(out_col_o)
        && $stable(out_row_o) && $stable(last_of_run_o) && $stable(frame_done_o);
  endproperty
  a_out_stable: assert property (p_out_stable) else $error("stalled result changed");

  // the frame's final result always closes its run
  property p_frame_last;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && frame_done_o |-> last_of_run_o;
  endproperty
  a_frame_last: assert property (p_frame_last) else $error("frame done without last of run");

  // one pixel in flight: no transfer right after a transfer
  property p_one_item;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o |=> !in_ready_o;
  endproperty
  a_one_item: assert property (p_one_item) else $error("pixel taken while busy");

endmodule

bind sobel_edge_magnitude_3x3 sem_checker #(
  .MAX_WIDTH (MAX_WIDTH)
) u_sem_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .magnitude_o   (magnitude_o),
  .out_col_o     (out_col_o),
  .out_row_o     (out_row_o),
  .last_of_run_o (last_of_run_o),
  .frame_done_o  (frame_done_o)
);
